### src/vgts_pkg.sv
package vgts_pkg;

  localparam int DIM_X = 32;
  localparam int DIM_Y = 32;
  localparam int DIM_Z = 32;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int ADDR_W = 15;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  localparam int XW = (DIM_X > 1) ? $clog2(DIM_X) : 1;
  localparam int YW = (DIM_Y > 1) ? $clog2(DIM_Y) : 1;
  localparam int ZW = (DIM_Z > 1) ? $clog2(DIM_Z) : 1;
  localparam int XYW = (XW > YW) ? XW : YW;
  localparam int IDX_W = (XYW > ZW) ? XYW : ZW;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_NEAREST = 2'd1,
    ACT_TRILIN  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SPLIT,
    F_PUSH
  } f_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } b_state_t;

  typedef struct packed {
    act_t                act;
    logic [ADDR_W-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;
    logic [IDX_W-1:0]    x0;
    logic [IDX_W-1:0]    x1;
    logic [IDX_W-1:0]    y0;
    logic [IDX_W-1:0]    y1;
    logic [IDX_W-1:0]    z0;
    logic [IDX_W-1:0]    z1;
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fy;
    logic [FRAC_W-1:0]   fz;
  } cmd_t;

endpackage

### src/voxel_grid_trilinear_sampler_core.sv
// The front takes one query at a time (three axes through one 32x32 multiplier).
// Back: a trilinear query makes eight reads on the single voxel RAM port, with the
// blends through one blend multiplier interleaved; a 2-entry queue sits between.
// Reset (rst_n low, synchronous) empties the pipe and restores origin 0, step 1.0;
// the voxel RAM is not cleared and holds garbage until written.
module voxel_grid_trilinear_sampler_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_action,
  input  logic [vgts_pkg::ADDR_W-1:0] in_voxel_address,
  input  logic [vgts_pkg::DATA_W-1:0] in_voxel_value,
  input  logic [vgts_pkg::DATA_W-1:0] in_point_x,
  input  logic [vgts_pkg::DATA_W-1:0] in_point_y,
  input  logic [vgts_pkg::DATA_W-1:0] in_point_z,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [vgts_pkg::DATA_W-1:0] out_sample_value,
  input  logic                        cfg_wr_en,
  input  logic [2:0]                  cfg_index,
  input  logic [vgts_pkg::DATA_W-1:0] cfg_data
);
  import vgts_pkg::*;

  cmd_t fq_cmd, qb_cmd;
  logic fq_push, fq_full, qb_pop, qb_empty;

  vgts_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_voxel_address (in_voxel_address),
    .in_voxel_value   (in_voxel_value),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_full           (fq_full),
    .q_push           (fq_push),
    .q_cmd            (fq_cmd)
  );

  vgts_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_cmd),
    .full  (fq_full),
    .pop   (qb_pop),
    .dout  (qb_cmd),
    .empty (qb_empty)
  );

  vgts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (qb_empty),
    .q_head           (qb_cmd),
    .q_pop            (qb_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_sample_value (out_sample_value)
  );

endmodule

### src/vgts_front.sv
module vgts_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_action,
  input  logic [vgts_pkg::ADDR_W-1:0] in_voxel_address,
  input  logic [vgts_pkg::DATA_W-1:0] in_voxel_value,
  input  logic [vgts_pkg::DATA_W-1:0] in_point_x,
  input  logic [vgts_pkg::DATA_W-1:0] in_point_y,
  input  logic [vgts_pkg::DATA_W-1:0] in_point_z,
  input  logic                        cfg_wr_en,
  input  logic [2:0]                  cfg_index,
  input  logic [vgts_pkg::DATA_W-1:0] cfg_data,
  input  logic                        q_full,
  output logic                        q_push,
  output vgts_pkg::cmd_t              q_cmd
);
  import vgts_pkg::*;

  localparam logic [2:0] CFG_ORG_X = 3'd0;
  localparam logic [2:0] CFG_ORG_Y = 3'd1;
  localparam logic [2:0] CFG_ORG_Z = 3'd2;
  localparam logic [2:0] CFG_INV_X = 3'd3;
  localparam logic [2:0] CFG_INV_Y = 3'd4;
  localparam logic [2:0] CFG_INV_Z = 3'd5;
  localparam logic [1:0] AXIS_LAST = 2'd2;
  localparam logic [DATA_W-1:0] INV_RESET = 32'h0001_0000;

  f_state_t state_r, state_nxt;

  logic [DATA_W-1:0] org_r [3];
  logic [DATA_W-1:0] inv_r [3];

  act_t              act_r;
  logic [ADDR_W-1:0] waddr_r;
  logic [DATA_W-1:0] wdata_r;
  logic [DATA_W-1:0] pt_r [3];
  logic [1:0]        axis_r;
  logic [63:0]       prod_r, prod_nxt;
  logic [IDX_W-1:0]  lo_r [3];
  logic [IDX_W-1:0]  hi_r [3];
  logic [FRAC_W-1:0] frac_r [3];

  logic [DATA_W-1:0] sel_pt, sel_org, sel_inv, dpos, cell_idx, dim_top;
  logic [DATA_W:0]   diff;
  logic [IDX_W-1:0]  lo_nxt, hi_nxt;

  // offset from origin, clamped at zero, times reciprocal step
  always_comb begin
    sel_pt   = pt_r[axis_r];
    sel_org  = org_r[axis_r];
    sel_inv  = inv_r[axis_r];
    diff     = {sel_pt[DATA_W-1], sel_pt} - {sel_org[DATA_W-1], sel_org};
    dpos     = diff[DATA_W] ? '0 : diff[DATA_W-1:0];
    prod_nxt = 64'(dpos) * 64'(sel_inv);
  end

  always_comb begin
    cell_idx = prod_r[63:32];
    case (axis_r)
      2'd0:    dim_top = 32'(DIM_X - 1);
      2'd1:    dim_top = 32'(DIM_Y - 1);
      default: dim_top = 32'(DIM_Z - 1);
    endcase
    lo_nxt = (cell_idx > dim_top) ? dim_top[IDX_W-1:0] : cell_idx[IDX_W-1:0];
    hi_nxt = (cell_idx >= dim_top) ? dim_top[IDX_W-1:0] : IDX_W'(cell_idx + 32'd1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          case (act_t'(in_action))
            ACT_WRITE:               state_nxt = F_PUSH;
            ACT_NEAREST, ACT_TRILIN: state_nxt = F_MUL;
            default:                 state_nxt = F_IDLE;
          endcase
        end
      end
      F_MUL:   state_nxt = F_SPLIT;
      F_SPLIT: state_nxt = (axis_r == AXIS_LAST) ? F_PUSH : F_MUL;
      F_PUSH:  state_nxt = q_full ? F_PUSH : F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_full = (state_r != F_IDLE);
    q_push  = (state_r == F_PUSH) && !q_full;
    q_cmd.act   = act_r;
    q_cmd.waddr = waddr_r;
    q_cmd.wdata = wdata_r;
    q_cmd.x0    = lo_r[0];
    q_cmd.x1    = hi_r[0];
    q_cmd.y0    = lo_r[1];
    q_cmd.y1    = hi_r[1];
    q_cmd.z0    = lo_r[2];
    q_cmd.z1    = hi_r[2];
    q_cmd.fx    = frac_r[0];
    q_cmd.fy    = frac_r[1];
    q_cmd.fz    = frac_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      axis_r   <= '0;
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      inv_r[0] <= INV_RESET;
      inv_r[1] <= INV_RESET;
      inv_r[2] <= INV_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ORG_X: org_r[0] <= cfg_data;
          CFG_ORG_Y: org_r[1] <= cfg_data;
          CFG_ORG_Z: org_r[2] <= cfg_data;
          CFG_INV_X: inv_r[0] <= cfg_data;
          CFG_INV_Y: inv_r[1] <= cfg_data;
          CFG_INV_Z: inv_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == F_IDLE) begin
        axis_r <= '0;
      end else if (state_r == F_SPLIT) begin
        axis_r <= axis_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_push) begin
      act_r   <= act_t'(in_action);
      waddr_r <= in_voxel_address;
      wdata_r <= in_voxel_value;
      pt_r[0] <= in_point_x;
      pt_r[1] <= in_point_y;
      pt_r[2] <= in_point_z;
    end
    if (state_r == F_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == F_SPLIT) begin
      lo_r[axis_r]   <= lo_nxt;
      hi_r[axis_r]   <= hi_nxt;
      frac_r[axis_r] <= prod_r[31:16];
    end
  end

endmodule

### src/vgts_queue.sv
module vgts_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vgts_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output vgts_pkg::cmd_t dout,
  output logic           empty
);
  import vgts_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;

  always_comb begin
    full  = (count_r == QCNT_W'(QDEPTH));
    empty = (count_r == '0);
    dout  = slot_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= din;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCNT_W'(QDEPTH)))
    else $error("queue overrun");

  a_pop_held: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue underrun");

endmodule

### src/vgts_back.sv
module vgts_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  vgts_pkg::cmd_t              q_head,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [vgts_pkg::DATA_W-1:0] out_sample_value
);
  import vgts_pkg::*;

  localparam logic [3:0] STEP_NEAR = 4'd1;
  localparam logic [3:0] STEP_YB0  = 4'd9;
  localparam logic [3:0] STEP_YB1  = 4'd10;
  localparam logic [3:0] STEP_LAST = 4'd11;

  b_state_t state_r, state_nxt;

  logic [DATA_W-1:0] store_r [STORE_DEPTH];

  cmd_t              cmd_r;
  logic [3:0]        step_r;
  logic [DATA_W-1:0] rd_r, a_r;
  logic [DATA_W-1:0] zv_r [4];
  logic [DATA_W-1:0] yv_r [2];
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic              start, wr_en, done;
  logic [IDX_W-1:0]  xi, yi, zi;
  logic [31:0]       addr_full;
  logic [ADDR_W-1:0] raddr;
  logic [2:0]        zslot;

  logic [DATA_W-1:0]  bl_a, bl_b, bl_res;
  logic [FRAC_W-1:0]  bl_f;
  logic signed [DATA_W:0]   bl_diff;
  logic signed [49:0]       bl_prod;
  logic [DATA_W+1:0]        bl_sum;

  // corner order: x in bit 2, y in bit 1, z in bit 0 of the step
  always_comb begin
    xi = step_r[2] ? cmd_r.x1 : cmd_r.x0;
    yi = step_r[1] ? cmd_r.y1 : cmd_r.y0;
    zi = step_r[0] ? cmd_r.z1 : cmd_r.z0;
    addr_full = (32'(xi) * 32'(DIM_Y) + 32'(yi)) * 32'(DIM_Z) + 32'(zi);
    raddr = addr_full[ADDR_W-1:0];
    zslot = step_r[3:1] - 3'd1;
  end

  // floor((a*(1-f) + b*f)) == a + floor((b-a)*f)
  always_comb begin
    bl_a = a_r;
    bl_b = rd_r;
    bl_f = cmd_r.fz;
    case (step_r)
      STEP_YB0: begin
        bl_a = zv_r[0];
        bl_b = zv_r[1];
        bl_f = cmd_r.fy;
      end
      STEP_YB1: begin
        bl_a = zv_r[2];
        bl_b = zv_r[3];
        bl_f = cmd_r.fy;
      end
      STEP_LAST: begin
        bl_a = yv_r[0];
        bl_b = yv_r[1];
        bl_f = cmd_r.fx;
      end
      default: ;
    endcase
    bl_diff = $signed({bl_b[DATA_W-1], bl_b}) - $signed({bl_a[DATA_W-1], bl_a});
    bl_prod = bl_diff * $signed({1'b0, bl_f});
    bl_sum  = {{2{bl_a[DATA_W-1]}}, bl_a} + bl_prod[49:16];
    bl_res  = bl_sum[DATA_W-1:0];
  end

  always_comb begin
    start = 1'b0;
    q_pop = 1'b0;
    wr_en = 1'b0;
    if (state_r == B_IDLE && !q_empty) begin
      case (q_head.act)
        ACT_WRITE: begin
          q_pop = 1'b1;
          wr_en = 1'b1;
        end
        ACT_NEAREST, ACT_TRILIN: begin
          if (!out_valid_r) begin
            q_pop = 1'b1;
            start = 1'b1;
          end
        end
        default: q_pop = 1'b1;
      endcase
    end
    done = (state_r == B_RUN) &&
           ((cmd_r.act == ACT_NEAREST && step_r == STEP_NEAR) || step_r == STEP_LAST);
    out_empty        = !out_valid_r;
    out_sample_value = out_data_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  state_nxt = start ? B_RUN : B_IDLE;
      B_RUN:   state_nxt = done ? B_IDLE : B_RUN;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        step_r <= '0;
      end else if (state_r == B_RUN) begin
        step_r <= step_r + 4'd1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[q_head.waddr] <= q_head.wdata;
    end
    rd_r <= store_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= q_head;
    end
    if (state_r == B_RUN) begin
      if (step_r[0] && !step_r[3]) begin
        a_r <= rd_r;
      end
      if (!step_r[0] && step_r >= 4'd2 && step_r <= 4'd8) begin
        zv_r[zslot[1:0]] <= bl_res;
      end
      if (step_r == STEP_YB0) begin
        yv_r[0] <= bl_res;
      end
      if (step_r == STEP_YB1) begin
        yv_r[1] <= bl_res;
      end
    end
    if (done) begin
      out_data_r <= (cmd_r.act == ACT_NEAREST) ? rd_r : bl_res;
    end
  end

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !out_valid_r)
    else $error("result slot overwritten");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN) |-> (step_r <= STEP_LAST))
    else $error("step beyond blend sequence");

  a_near_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN && cmd_r.act == ACT_NEAREST) |-> (step_r <= STEP_NEAR))
    else $error("nearest query overran");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vgts_pkg::*;

  localparam int CFG_ORIGIN_X   = 0;
  localparam int CFG_INV_STEP_X = 3;
  localparam int CFG_INV_STEP_Z = 5;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 40;

  class sample_scoreboard;
    logic signed [DATA_W-1:0] origin [3];
    logic [DATA_W-1:0] inv_step [3];
    logic [DATA_W-1:0] voxels [STORE_DEPTH];
    logic [DATA_W-1:0] expected_samples [$];
    int errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        origin[i] = '0;
        inv_step[i] = 32'h0001_0000;
      end
      errors = 0;
    endfunction

    function void set_cfg(int idx, logic [DATA_W-1:0] data);
      if (idx < CFG_INV_STEP_X) origin[idx - CFG_ORIGIN_X] = data;
      else inv_step[idx - CFG_INV_STEP_X] = data;
    endfunction

    function void scale_axis(int axis, logic [DATA_W-1:0] p, int dim, output int lo,
                             output int hi, output logic [FRAC_W-1:0] frac);
      logic signed [DATA_W:0] d;
      logic [2*DATA_W-1:0] prod;
      d = $signed({p[DATA_W-1], p}) - $signed({origin[axis][DATA_W-1], origin[axis]});
      if (d < 0) d = '0;
      prod = {32'd0, d[DATA_W-1:0]} * {32'd0, inv_step[axis]};
      frac = prod[31:16];
      if (prod[63:32] >= dim - 1) begin
        lo = dim - 1;
        hi = dim - 1;
      end else begin
        lo = prod[63:32];
        hi = lo + 1;
      end
    endfunction

    // corner i: bit 2 selects x, bit 1 y, bit 0 z
    function void corner_addrs(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                               logic [DATA_W-1:0] pz, output int adr [8],
                               output logic [FRAC_W-1:0] fr [3]);
      int xs [2];
      int ys [2];
      int zs [2];
      scale_axis(0, px, DIM_X, xs[0], xs[1], fr[0]);
      scale_axis(1, py, DIM_Y, ys[0], ys[1], fr[1]);
      scale_axis(2, pz, DIM_Z, zs[0], zs[1], fr[2]);
      for (int i = 0; i < 8; i++)
        adr[i] = ((xs[i >> 2] * DIM_Y + ys[(i >> 1) & 1]) * DIM_Z + zs[i & 1])
                 & (STORE_DEPTH - 1);
    endfunction

    function logic signed [DATA_W-1:0] blend(logic signed [DATA_W-1:0] a,
                                             logic signed [DATA_W-1:0] b,
                                             logic [FRAC_W-1:0] f);
      longint s;
      s = longint'(a) * (longint'(65536) - longint'(f)) + longint'(b) * longint'(f);
      return 32'(s >>> 16);
    endfunction

    function void note_input(logic [1:0] act, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] val, logic [DATA_W-1:0] px,
                             logic [DATA_W-1:0] py, logic [DATA_W-1:0] pz);
      int adr [8];
      logic [FRAC_W-1:0] fr [3];
      logic signed [DATA_W-1:0] zb [4];
      logic signed [DATA_W-1:0] yb [2];
      case (act)
        ACT_WRITE: voxels[addr] = val;
        ACT_NEAREST: begin
          corner_addrs(px, py, pz, adr, fr);
          expected_samples.push_back(voxels[adr[0]]);
        end
        ACT_TRILIN: begin
          corner_addrs(px, py, pz, adr, fr);
          for (int i = 0; i < 4; i++)
            zb[i] = blend(voxels[adr[2*i]], voxels[adr[2*i+1]], fr[2]);
          yb[0] = blend(zb[0], zb[1], fr[1]);
          yb[1] = blend(zb[2], zb[3], fr[1]);
          expected_samples.push_back(blend(yb[0], yb[1], fr[0]));
        end
        default: ;
      endcase
    endfunction

    function void check_sample(logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] exp_v;
      if (expected_samples.size() == 0) begin
        $error("sample_value: expected none, actual %h", actual);
        errors++;
        return;
      end
      exp_v = expected_samples.pop_front();
      if (actual !== exp_v) begin
        $error("sample_value: expected %h, actual %h", exp_v, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_action = ACT_UNUSED;
  logic [ADDR_W-1:0] in_voxel_address = '0;
  logic [DATA_W-1:0] in_voxel_value = '0;
  logic [DATA_W-1:0] in_point_x = '0;
  logic [DATA_W-1:0] in_point_y = '0;
  logic [DATA_W-1:0] in_point_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [DATA_W-1:0] out_sample_value;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  sample_scoreboard sb = new();
  bit written [STORE_DEPTH];
  int snd_idle = 0;
  int rcv_idle = 0;
  int items_sent = 0;

  voxel_grid_trilinear_sampler_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_voxel_address (in_voxel_address),
    .in_voxel_value   (in_voxel_value),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_sample_value (out_sample_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_sample(out_sample_value);
    out_pop <= rst_n && ($urandom_range(0, 99) >= rcv_idle);
  end

  task automatic send_item(logic [1:0] act, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val,
                           logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                           logic [DATA_W-1:0] pz);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_action <= act;
    in_voxel_address <= addr;
    in_voxel_value <= val;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    do @(posedge clk); while (in_full);
    sb.note_input(act, addr, val, px, py, pz);
    items_sent++;
  endtask

  task automatic write_voxel(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    written[addr] = 1'b1;
    send_item(ACT_WRITE, addr, val, $urandom(), $urandom(), $urandom());
  endtask

  // load any unwritten corner first so the query never reads stale RAM
  task automatic query(logic [1:0] act, logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                       logic [DATA_W-1:0] pz);
    int adr [8];
    logic [FRAC_W-1:0] fr [3];
    sb.corner_addrs(px, py, pz, adr, fr);
    for (int i = 0; i < 8; i++)
      if (!written[adr[i]]) write_voxel(ADDR_W'(adr[i]), $urandom());
    send_item(act, ADDR_W'($urandom()), $urandom(), px, py, pz);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(int phase);
    logic [DATA_W-1:0] v [6];
    for (int i = 0; i < 3; i++) begin
      case (phase)
        0: begin
          v[CFG_ORIGIN_X + i] = 32'h0;
          v[CFG_INV_STEP_X + i] = 32'h0001_0000;
        end
        1: begin
          v[CFG_ORIGIN_X + i] = 32'h8000_0000;
          v[CFG_INV_STEP_X + i] = 32'h0000_0100;
        end
        2: begin
          v[CFG_ORIGIN_X + i] = 32'h7FFF_FFFF;
          v[CFG_INV_STEP_X + i] = 32'hFFFF_FFFF;
        end
        3: begin
          v[CFG_ORIGIN_X + i] = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
          v[CFG_INV_STEP_X + i] = $urandom_range(32'h4000, 32'h4_0000);
        end
        4: begin
          v[CFG_ORIGIN_X + i] = $urandom();
          v[CFG_INV_STEP_X + i] = (i == 0) ? 32'h0 : $urandom_range(32'h1000, 32'h10_0000);
        end
        default: begin
          v[CFG_ORIGIN_X + i] = $urandom();
          v[CFG_INV_STEP_X + i] = $urandom();
        end
      endcase
    end
    for (int i = CFG_ORIGIN_X; i <= CFG_INV_STEP_Z; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk);
      sb.set_cfg(i, v[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_coord(int axis);
    longint unsigned span;
    int sel;
    sel = $urandom_range(0, 99);
    if (sb.inv_step[axis] == 0) span = 64'hFFFF_FFFF;
    else span = (64'd34 << 32) / sb.inv_step[axis];
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if (sel < 10) return $urandom();
    if (sel < 20) return sb.origin[axis] - $urandom_range(1, 1 << 20);
    return sb.origin[axis] + 32'({$urandom(), $urandom()} % (span + 1));
  endfunction

  initial begin
    logic [DATA_W-1:0] cube_vals [8];
    int sel;
    int phase_start;
    bit mid_done;
    cube_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h8000_0001};
    mid_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle = 24;
    rcv_idle = 69;

    for (int i = 0; i < 8; i++)
      write_voxel(ADDR_W'(((i >> 2) * DIM_Y + ((i >> 1) & 1)) * DIM_Z + (i & 1)),
                  cube_vals[i]);
    query(ACT_NEAREST, 32'h0, 32'h0, 32'h0);
    query(ACT_TRILIN, 32'h0, 32'h0, 32'h0);
    query(ACT_TRILIN, 32'h8000, 32'h8000, 32'h8000);
    query(ACT_TRILIN, 32'hFFFF, 32'hFFFF, 32'hFFFF);
    query(ACT_TRILIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    query(ACT_NEAREST, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0000_C000);
    query(ACT_TRILIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(ACT_NEAREST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(ACT_TRILIN, 32'h001E_8000, 32'h001F_4000, 32'h0000_8000);
    send_item(ACT_UNUSED, ADDR_W'($urandom()), $urandom(), $urandom(), $urandom(),
              $urandom());
    send_item(ACT_UNUSED, '1, '1, '1, '1, '1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      snd_idle = (phase < 2) ? 24 : (phase < 4) ? 69 : 0;
      rcv_idle = (phase < 2) ? 69 : (phase < 4) ? 24 : 0;
      apply_config(phase);
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if (phase == 0 && !mid_done && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
          drain();
          mid_done = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 20) write_voxel(ADDR_W'($urandom()), $urandom());
        else if (sel < 25)
          send_item(ACT_UNUSED, ADDR_W'($urandom()), $urandom(), $urandom(), $urandom(),
                    $urandom());
        else
          query((sel < 60) ? ACT_NEAREST : ACT_TRILIN, rand_coord(0), rand_coord(1),
                rand_coord(2));
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
